// ===== design/symmetric_3x3_inverse_macros.svh =====
// Assertion macros used by symmetric_3x3_inverse.sv
`ifndef SYMMETRIC_3X3_INVERSE_MACROS_SVH
`define SYMMETRIC_3X3_INVERSE_MACROS_SVH

`define S3I_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s3i assertion failed");

`define S3I_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s3i assertion failed");

`endif

// ===== design/s3i_pkg.sv =====
package s3i_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int KW  = 2 * VALUE_WIDTH + 1;
    localparam int DW  = 3 * VALUE_WIDTH + 3;
    localparam int CW  = DW + VALUE_WIDTH;
    localparam int PW  = 2 * VALUE_WIDTH;
    localparam int LW  = VALUE_WIDTH + 1;
    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = VALUE_WIDTH + 2;
    localparam int LAT       = FRONT_LAT + LANE_LAT;
    localparam int NLANE     = 6;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;
    typedef logic signed [KW-1:0] cof_t;
    typedef logic signed [DW-1:0] det_t;

    typedef struct packed {
        val_t m11;
        val_t m12;
        val_t m13;
        val_t m22;
        val_t m23;
        val_t m33;
        logic want_covariant;
    } in_t;

    typedef struct packed {
        val_t r11;
        val_t r12;
        val_t r13;
        val_t r22;
        val_t r23;
        val_t r33;
        logic singular;
    } out_t;

endpackage

// ===== design/s3i_front.sv =====
module s3i_front (
    input  logic               clk,
    input  s3i_pkg::in_t       item,
    output s3i_pkg::cof_t      cof [s3i_pkg::NLANE],
    output s3i_pkg::det_t      det
);
    import s3i_pkg::*;

    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [PW+1:0]   lprod_t;

    prod_t  p_reg [12];
    val_t   a1_reg, b1_reg, c1_reg;
    cof_t   k2_reg [NLANE];
    val_t   a2_reg, b2_reg, c2_reg;
    prod_t  ph3_reg [3];
    lprod_t pl3_reg [3];
    cof_t   k3_reg [NLANE];
    det_t   t4_reg [3];
    cof_t   k4_reg [NLANE];
    det_t   det5_reg;
    cof_t   k5_reg [NLANE];

    val_t   x2 [3];

    always_comb
    begin
        x2[0] = a2_reg;
        x2[1] = b2_reg;
        x2[2] = c2_reg;
    end

    always_ff @(posedge clk)
    begin
        p_reg[0]  <= item.m22 * item.m33;
        p_reg[1]  <= item.m23 * item.m23;
        p_reg[2]  <= item.m13 * item.m23;
        p_reg[3]  <= item.m12 * item.m33;
        p_reg[4]  <= item.m12 * item.m23;
        p_reg[5]  <= item.m13 * item.m22;
        p_reg[6]  <= item.m11 * item.m33;
        p_reg[7]  <= item.m13 * item.m13;
        p_reg[8]  <= item.m12 * item.m13;
        p_reg[9]  <= item.m11 * item.m23;
        p_reg[10] <= item.m11 * item.m22;
        p_reg[11] <= item.m12 * item.m12;
        a1_reg <= item.m11;
        b1_reg <= item.m12;
        c1_reg <= item.m13;

        for (int j = 0; j < NLANE; j++)
        begin
            k2_reg[j] <= KW'(p_reg[2*j]) - KW'(p_reg[2*j+1]);
        end
        a2_reg <= a1_reg;
        b2_reg <= b1_reg;
        c2_reg <= c1_reg;

        for (int j = 0; j < 3; j++)
        begin
            ph3_reg[j] <= x2[j] * $signed(k2_reg[j][KW-1:LW]);
            pl3_reg[j] <= (PW+2)'(x2[j]) * $signed({2'b00, k2_reg[j][LW-1:0]});
        end
        k3_reg <= k2_reg;

        for (int j = 0; j < 3; j++)
        begin
            t4_reg[j] <= (DW'(ph3_reg[j]) <<< LW) + DW'(pl3_reg[j]);
        end
        k4_reg <= k3_reg;

        det5_reg <= t4_reg[0] + t4_reg[1] + t4_reg[2];
        k5_reg   <= k4_reg;
    end

    assign cof = k5_reg;
    assign det = det5_reg;

endmodule

// ===== design/s3i_lane.sv =====
module s3i_lane (
    input  logic             clk,
    input  s3i_pkg::cof_t    cof,
    input  s3i_pkg::det_t    det,
    output s3i_pkg::val_t    quo,
    output logic             zero
);
    import s3i_pkg::*;

    logic [CW-1:0]          nmag_reg;
    logic [DW-1:0]          dmag_reg;
    logic                   neg_reg;
    logic                   zero_reg;

    logic [CW-1:0]          rem_reg  [VALUE_WIDTH];
    logic [DW-1:0]          dv_reg   [VALUE_WIDTH];
    logic [VALUE_WIDTH-2:0] q_reg    [VALUE_WIDTH];
    logic                   ovf_reg  [VALUE_WIDTH];
    logic                   sgn_reg  [VALUE_WIDTH];
    logic                   zr_reg   [VALUE_WIDTH];

    val_t                   quo_reg;
    logic                   zero_out_reg;

    logic [KW-1:0]          kabs;
    logic [VALUE_WIDTH-1:0] qext;

    always_comb
    begin
        kabs = cof[KW-1] ? KW'(-cof) : KW'(cof);
        qext = {1'b0, q_reg[VALUE_WIDTH-1]};
    end

    always_ff @(posedge clk)
    begin
        nmag_reg <= CW'(kabs) << (2 * FRACTION_BITS);
        dmag_reg <= det[DW-1] ? DW'(-det) : DW'(det);
        neg_reg  <= cof[KW-1] ^ det[DW-1];
        zero_reg <= (det == '0);

        rem_reg[0] <= nmag_reg;
        dv_reg[0]  <= dmag_reg;
        q_reg[0]   <= '0;
        ovf_reg[0] <= nmag_reg >= (CW'(dmag_reg) << (VALUE_WIDTH - 1));
        sgn_reg[0] <= neg_reg;
        zr_reg[0]  <= zero_reg;

        for (int s = 1; s < VALUE_WIDTH; s++)
        begin
            if (rem_reg[s-1] >= (CW'(dv_reg[s-1]) << (VALUE_WIDTH - 1 - s)))
            begin
                rem_reg[s] <= rem_reg[s-1] - (CW'(dv_reg[s-1]) << (VALUE_WIDTH - 1 - s));
                q_reg[s]   <= q_reg[s-1] | ((VALUE_WIDTH-1)'(1) << (VALUE_WIDTH - 1 - s));
            end
            else
            begin
                rem_reg[s] <= rem_reg[s-1];
                q_reg[s]   <= q_reg[s-1];
            end
            dv_reg[s]  <= dv_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            sgn_reg[s] <= sgn_reg[s-1];
            zr_reg[s]  <= zr_reg[s-1];
        end

        priority if (zr_reg[VALUE_WIDTH-1])
            quo_reg <= '0;
        else if (ovf_reg[VALUE_WIDTH-1])
            quo_reg <= sgn_reg[VALUE_WIDTH-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                              : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        else
            quo_reg <= sgn_reg[VALUE_WIDTH-1] ? -qext : qext;
        zero_out_reg <= zr_reg[VALUE_WIDTH-1];
    end

    assign quo  = quo_reg;
    assign zero = zero_out_reg;

endmodule

// ===== design/symmetric_3x3_inverse.sv =====
// channel   direction  handshake            payload
// item      in         start & !busy        in_t (six entries, want_covariant)
// result    out        done, one cycle      out_t (six entries, singular)
// config    in         cfg_we               cfg_wdata (stored_is_covariant)
//
// One item per cycle; busy stays low.
// Results pass through the front stages, the one-bit-per-stage divider and the output register.
// Reset clears stored_is_covariant and all valid bits.
// The receiver cannot stall; results leave in accept order.
module symmetric_3x3_inverse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  s3i_pkg::in_t   item,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    output logic           done,
    output s3i_pkg::out_t  result
);
    import s3i_pkg::*;
    `include "symmetric_3x3_inverse_macros.svh"

    logic  stored_reg;
    logic  vld_reg [LAT];
    logic  byp_reg [LAT];
    in_t   raw_reg [LAT];
    logic  done_reg;
    out_t  result_reg;

    cof_t  cof [NLANE];
    det_t  det;
    val_t  quo [NLANE];
    logic  zero [NLANE];
    logic  accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    s3i_front u_front (
        .clk  (clk),
        .item (item),
        .cof  (cof),
        .det  (det)
    );

    for (genvar j = 0; j < NLANE; j++)
    begin : g_lane
        s3i_lane u_lane (
            .clk  (clk),
            .cof  (cof[j]),
            .det  (det),
            .quo  (quo[j]),
            .zero (zero[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= 1'b0;
            done_reg   <= 1'b0;
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                stored_reg <= cfg_wdata;
            end
            vld_reg[0] <= accept;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg[0] <= item;
        byp_reg[0] <= (item.want_covariant == stored_reg);
        for (int i = 1; i < LAT; i++)
        begin
            raw_reg[i] <= raw_reg[i-1];
            byp_reg[i] <= byp_reg[i-1];
        end
        if (byp_reg[LAT-1])
        begin
            result_reg.r11      <= raw_reg[LAT-1].m11;
            result_reg.r12      <= raw_reg[LAT-1].m12;
            result_reg.r13      <= raw_reg[LAT-1].m13;
            result_reg.r22      <= raw_reg[LAT-1].m22;
            result_reg.r23      <= raw_reg[LAT-1].m23;
            result_reg.r33      <= raw_reg[LAT-1].m33;
            result_reg.singular <= 1'b0;
        end
        else
        begin
            result_reg.r11      <= quo[0];
            result_reg.r12      <= quo[1];
            result_reg.r13      <= quo[2];
            result_reg.r22      <= quo[3];
            result_reg.r23      <= quo[4];
            result_reg.r33      <= quo[5];
            result_reg.singular <= zero[0];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `S3I_ASSERT_IMP(a_never_busy, 1'b1, !busy)
    `S3I_ASSERT_IMP(a_latency, accept, ##(LAT + 1) done)
    `S3I_ASSERT_IMP(a_singular_zero, done && result.singular,
        result.r11 == '0 && result.r22 == '0 && result.r33 == '0)
    `S3I_ASSERT_NXT(a_no_spurious, !vld_reg[LAT-1], !done)

endmodule
